// ===== hdl/rats_pkg.sv =====
// Relay actuator test sequencer: shared types, register indexes and constants.
// Used by the status channel interface and every module of the block.
package rats_pkg;

	localparam int unsigned TimeClip = 250;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 16;
	localparam int unsigned TimerW = 8;

	typedef logic [TimerW-1:0] timer_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ON   = 2'd1,
		PH_OFF  = 2'd2,
		PH_END  = 2'd3
	} phase_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_CODE  = 3'd0,
		REG_ON    = 3'd1,
		REG_OFF   = 3'd2,
		REG_TOTAL = 3'd3,
		REG_HOLD  = 3'd4
	} reg_idx_t;

	// Times are kept already clipped; the clip only depends on the register value.
	typedef struct packed {
		logic [7:0] code;
		timer_t     on_ticks;
		timer_t     off_ticks;
		timer_t     total_ticks;
		timer_t     hold_ticks;
	} cfg_t;

	function automatic timer_t clip_time(input logic [CfgDataW-1:0] v);
		if (v > CfgDataW'(TimeClip))
			return TimerW'(TimeClip);
		else
			return v[TimerW-1:0];
	endfunction

endpackage

// ===== hdl/rats_if.sv =====
// Valid/ready channel interfaces for the sequencer's tick input and status output.
// Depends on rats_pkg for the phase type.
interface rats_in_if;
	logic       valid;
	logic       ready;
	logic       test_enable;
	logic [7:0] requested_code;

	modport source (output valid, output test_enable, output requested_code, input ready);
	modport sink (input valid, input test_enable, input requested_code, output ready);
endinterface

interface rats_out_if import rats_pkg::*;;
	logic   valid;
	logic   ready;
	logic   relay_command;
	logic   test_in_progress;
	logic   test_complete;
	phase_t phase;

	modport source (output valid, output relay_command, output test_in_progress,
		output test_complete, output phase, input ready);
	modport sink (input valid, input relay_command, input test_in_progress,
		input test_complete, input phase, output ready);
endinterface

// ===== hdl/relay_actuator_test_sequencer.sv =====
// Top level of the relay actuator test sequencer: input and result registers
// around the phase sequencer. Depends on rats_pkg, rats_if, rats_cfg_regs, rats_seq.
//
//  channel  dir  word fields
//  item     in   test_enable, requested_code
//  result   out  relay_command, test_in_progress, test_complete, phase
//  cfg_*    in   register index and write data, write-only
//
// One word per cycle while the result is not stalled. The accepted tick is latched
// in an input register, the sequencer updates, and the new phase lands in the
// result register, from which the flags decode.
// A stalled result holds the input register; the input still takes a word
// whenever that register drains in the same cycle. Reset puts the block in idle.
module relay_actuator_test_sequencer import rats_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	rats_in_if.sink             item,
	rats_out_if.source          result,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	cfg_t       cfg;
	logic       valid_s1;
	logic       test_enable_s1;
	logic [7:0] requested_code_s1;
	logic       valid_s2;
	phase_t     phase_s2;
	phase_t     phase_next;
	logic       advance;
	logic       take;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign take       = item.valid && item.ready;

	rats_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rats_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.test_enable    (test_enable_s1),
		.requested_code (requested_code_s1),
		.cfg            (cfg),
		.phase_next     (phase_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (result.ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			test_enable_s1    <= item.test_enable;
			requested_code_s1 <= item.requested_code;
		end
		if (advance)
			phase_s2 <= phase_next;
	end

	// flags follow from the phase alone
	assign result.valid            = valid_s2;
	assign result.phase            = phase_s2;
	assign result.relay_command    = (phase_s2 == PH_ON);
	assign result.test_in_progress = (phase_s2 == PH_ON) || (phase_s2 == PH_OFF);
	assign result.test_complete    = (phase_s2 == PH_END);

endmodule

// ===== hdl/rats_cfg_regs.sv =====
// Configuration register file; times are clipped as they are written.
// Depends on rats_pkg.
module rats_cfg_regs import rats_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CODE:  cfg_q.code        <= cfg_wdata[7:0];
				REG_ON:    cfg_q.on_ticks    <= clip_time({8'd0, cfg_wdata[7:0]});
				REG_OFF:   cfg_q.off_ticks   <= clip_time({8'd0, cfg_wdata[7:0]});
				REG_TOTAL: cfg_q.total_ticks <= clip_time(cfg_wdata);
				REG_HOLD:  cfg_q.hold_ticks  <= clip_time({8'd0, cfg_wdata[7:0]});
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/rats_seq.sv =====
// Phase state machine and its interval, total and hold timers.
// Advances one tick per step strobe; depends on rats_pkg.
module rats_seq import rats_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       test_enable,
	input  logic [7:0] requested_code,
	input  cfg_t       cfg,
	output phase_t     phase_next
);

	phase_t phase_q, phase_d;
	timer_t interval_q, interval_d;
	timer_t total_q, total_d;
	timer_t hold_q, hold_d;
	logic   enabled;

	assign enabled = test_enable && (requested_code == cfg.code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			interval_q <= '0;
			total_q    <= '0;
			hold_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			interval_q <= interval_d;
			total_q    <= total_d;
			hold_q     <= hold_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		interval_d = interval_q;
		total_d    = total_q;
		hold_d     = hold_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (enabled) begin
					phase_d    = PH_ON;
					interval_d = cfg.on_ticks;
					total_d    = cfg.total_ticks;
				end
			end
			PH_ON, PH_OFF: begin
				if (!enabled) begin
					phase_d = PH_IDLE;
				end else if (total_q <= TimerW'(1)) begin
					// total expiry wins over interval expiry
					phase_d = PH_END;
					hold_d  = cfg.hold_ticks;
				end else begin
					if (phase_q == PH_ON) begin
						if (interval_q <= TimerW'(1)) begin
							phase_d    = PH_OFF;
							interval_d = cfg.off_ticks;
						end else begin
							interval_d = interval_q - TimerW'(1);
						end
					end else if (interval_q != '0) begin
						interval_d = interval_q - TimerW'(1);
					end
					total_d = total_q - TimerW'(1);
				end
			end
			PH_END: begin
				if (enabled && hold_q == '0)
					phase_d = PH_IDLE;
				else if (hold_q != '0)
					hold_d = hold_q - TimerW'(1);
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	assign phase_next = phase_d;

endmodule
